// File: src/rrsof_pkg.sv
// ----------------------------------------------------------------------------
// rrsof_pkg: shared definitions for the record ring with offset lookup
// Widths, ring geometry, payload types and small slot helpers.
// ----------------------------------------------------------------------------
package rrsof_pkg;

    localparam int RING_DEPTH   = 16;
    localparam int HANDLE_W     = 32;
    localparam int SIZE_W       = 16;
    localparam int POS_W        = 24;
    localparam int SLOT_FIELD_W = 4;

    localparam int SLOT_W  = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = SIZE_W + SLOT_W;
    localparam int CMP_W   = (POS_W > SUM_W) ? POS_W : SUM_W;
    localparam int ENTRY_W = HANDLE_W + SIZE_W;

    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [HANDLE_W-1:0]     handle_t;
    typedef logic [SIZE_W-1:0]       rec_size_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef logic [SLOT_FIELD_W-1:0] slot_field_t;
    typedef logic [ENTRY_W-1:0]      entry_t;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_FIND = 1'b1
    } op_t;

    // Control from the sequencer to the accumulate and compare unit.
    typedef struct packed {
        logic load;
        logic advance;
    } acc_ctrl_t;

    localparam slot_t LAST_SLOT = slot_t'(RING_DEPTH - 1);

    function automatic slot_t next_slot(input slot_t s);
        slot_t r;
        r = (s == LAST_SLOT) ? '0 : slot_t'(s + slot_t'(1));
        return r;
    endfunction

    // The reported slot keeps only the low bits that fit its field.
    function automatic slot_field_t to_slot_field(input slot_t s);
        logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, s};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

// File: src/rrsof_if.sv
// ----------------------------------------------------------------------------
// rrsof_if: request and response channels
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rrsof_req_if import rrsof_pkg::*; ();
    logic      valid;
    logic      ready;
    logic      op;
    handle_t   record_handle;
    rec_size_t record_size;
    pos_t      byte_position;

    modport source (
        output valid, op, record_handle, record_size, byte_position,
        input  ready
    );
    modport sink (
        input  valid, op, record_handle, record_size, byte_position,
        output ready
    );
endinterface

interface rrsof_rsp_if import rrsof_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        found;
    slot_field_t slot;
    handle_t     found_handle;
    rec_size_t   offset_in_record;

    modport source (
        output valid, found, slot, found_handle, offset_in_record,
        input  ready
    );
    modport sink (
        input  valid, found, slot, found_handle, offset_in_record,
        output ready
    );
endinterface

// File: src/rrsof_ram.sv
// ----------------------------------------------------------------------------
// rrsof_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrsof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/rrsof_accum.sv
// ----------------------------------------------------------------------------
// rrsof_accum: running byte count and offset compare
// Holds the searched position and the bytes before the current record, and
// decides whether the current record holds the position.
// ----------------------------------------------------------------------------
module rrsof_accum import rrsof_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  acc_ctrl_t ctrl,
    input  pos_t      pos_in,
    input  rec_size_t size,
    output logic      hit,
    output rec_size_t offset
);

    pos_t             pos_reg;
    pos_t             pos_next;
    sum_t             before_reg;
    sum_t             before_next;
    logic [CMP_W-1:0] end_sum;
    logic [CMP_W-1:0] diff;

    assign end_sum = CMP_W'(before_reg) + CMP_W'(size);
    assign diff    = CMP_W'(pos_reg) - CMP_W'(before_reg);
    assign hit     = CMP_W'(pos_reg) < end_sum;
    assign offset  = diff[SIZE_W-1:0];

    always_comb
    begin
        pos_next    = pos_reg;
        before_next = before_reg;
        if (ctrl.load)
        begin
            pos_next    = pos_in;
            before_next = '0;
        end
        else if (ctrl.advance)
        begin
            before_next = end_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            before_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            before_reg <= before_next;
        end
    end

endmodule

// File: src/ring_record_store_offset_find.sv
// ----------------------------------------------------------------------------
// ring_record_store_offset_find: overwriting record ring with offset lookup
// Stores handle/size records in a ring and finds the record holding an offset.
// ----------------------------------------------------------------------------
// An add beat writes the record at the write slot, and the oldest record is
// dropped once the ring is full; it gives no response. A find beat walks the
// stored records from oldest to newest, one record per cycle through the
// single read port of the record RAM; a find on an empty ring answers not
// found without a walk. The request channel is not ready during a walk, nor
// while an earlier response waits and is not taken.
// ----------------------------------------------------------------------------
module ring_record_store_offset_find import rrsof_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    rrsof_req_if.sink   req,
    rrsof_rsp_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    slot_t       write_slot_reg;
    slot_t       write_slot_next;
    slot_t       read_slot_reg;
    slot_t       read_slot_next;
    logic        full_reg;
    logic        full_next;
    slot_t       idx_reg;
    slot_t       idx_next;
    cnt_t        left_reg;
    cnt_t        left_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        found_reg;
    logic        found_next;
    slot_field_t slot_reg;
    slot_field_t slot_next;
    handle_t     handle_reg;
    handle_t     handle_next;
    rec_size_t   offset_reg;
    rec_size_t   offset_next;

    logic        accept;
    logic        add_go;
    logic        find_go;
    cnt_t        count;
    slot_t       ws_adv;
    slot_t       rs_adv;
    slot_t       rd_addr;
    entry_t      rd_data;
    acc_ctrl_t   acc_ctrl;
    logic        hit;
    rec_size_t   hit_offset;
    handle_t     rd_handle;
    rec_size_t   rd_size;

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign add_go    = accept && (op_t'(req.op) == OP_ADD);
    assign find_go   = accept && (op_t'(req.op) == OP_FIND);

    assign ws_adv = next_slot(write_slot_reg);
    assign rs_adv = next_slot(read_slot_reg);

    always_comb
    begin
        if (full_reg)
        begin
            count = cnt_t'(RING_DEPTH);
        end
        else if (write_slot_reg >= read_slot_reg)
        begin
            count = cnt_t'(write_slot_reg) - cnt_t'(read_slot_reg);
        end
        else
        begin
            count = cnt_t'(write_slot_reg) + cnt_t'(RING_DEPTH) - cnt_t'(read_slot_reg);
        end
    end

    // While walking, the read for the following record is issued each cycle.
    assign rd_addr = (state_reg == S_SCAN) ? next_slot(idx_reg) : read_slot_reg;

    rrsof_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (add_go),
        .wr_addr (write_slot_reg),
        .wr_data ({req.record_handle, req.record_size}),
        .rd_en   (1'b1),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_handle = rd_data[ENTRY_W-1:SIZE_W];
    assign rd_size   = rd_data[SIZE_W-1:0];

    assign acc_ctrl.load    = find_go;
    assign acc_ctrl.advance = (state_reg == S_SCAN) && !hit;

    rrsof_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .pos_in (req.byte_position),
        .size   (rd_size),
        .hit    (hit),
        .offset (hit_offset)
    );

    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        full_next       = full_reg;
        idx_next        = idx_reg;
        left_next       = left_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        found_next      = found_reg;
        slot_next       = slot_reg;
        handle_next     = handle_reg;
        offset_next     = offset_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (add_go)
                begin
                    write_slot_next = ws_adv;
                    if (full_reg)
                    begin
                        read_slot_next = rs_adv;
                    end
                    if (ws_adv == (full_reg ? rs_adv : read_slot_reg))
                    begin
                        full_next = 1'b1;
                    end
                end
                else if (find_go)
                begin
                    if (count == '0)
                    begin
                        rsp_valid_next = 1'b1;
                        found_next     = 1'b0;
                        slot_next      = '0;
                        handle_next    = '0;
                        offset_next    = '0;
                    end
                    else
                    begin
                        idx_next   = read_slot_reg;
                        left_next  = count;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = 1'b1;
                    slot_next      = to_slot_field(idx_reg);
                    handle_next    = rd_handle;
                    offset_next    = hit_offset;
                    state_next     = S_IDLE;
                end
                else if (left_reg == cnt_t'(1))
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = 1'b0;
                    slot_next      = '0;
                    handle_next    = '0;
                    offset_next    = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next  = next_slot(idx_reg);
                    left_next = left_reg - cnt_t'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            full_reg       <= 1'b0;
            idx_reg        <= '0;
            left_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            handle_reg     <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            full_reg       <= full_next;
            idx_reg        <= idx_next;
            left_reg       <= left_next;
            rsp_valid_reg  <= rsp_valid_next;
            found_reg      <= found_next;
            slot_reg       <= slot_next;
            handle_reg     <= handle_next;
            offset_reg     <= offset_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.found            = found_reg;
    assign rsp.slot             = slot_reg;
    assign rsp.found_handle     = handle_reg;
    assign rsp.offset_in_record = offset_reg;

    // A full ring always has its write and read slots together.
    a_full_slots: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (write_slot_reg == read_slot_reg))
        else $error("ring full with write and read slots apart");

    // Once full, the ring stays full until reset.
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("full flag cleared without reset");

    // A walk always has at least one record left to examine.
    a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (left_reg != '0))
        else $error("record walk with no records left");

    // A walk never runs while an earlier response is still pending.
    a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !rsp_valid_reg)
        else $error("record walk while a response waits");

    // A not-found response carries all-zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !found_reg) |->
            (slot_reg == '0 && handle_reg == '0 && offset_reg == '0))
        else $error("not-found response with nonzero fields");

endmodule
